// ===== hdl/byte_stream_cipher_macros.svh =====
// Assertion macros for the byte stream cipher.
// Uses the clk and rst_n names of the module that includes this header.
`ifndef BYTE_STREAM_CIPHER_MACROS_SVH
`define BYTE_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, held off during reset
`define BSC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define BSC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bsc_pkg.sv =====
// Shared types and constants for the byte stream cipher.
// No dependencies.
package bsc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int KLEN_W    = 5;
    localparam int TABLE_D   = 256;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD,
        CFG_SHIFT,
        CFG_KEY_LEN,
        CFG_KEY_LOW,
        CFG_KEY_HIGH
    } cfg_index_t;

    // Cipher method codes
    typedef enum logic [1:0] {
        METH_CAESAR,
        METH_VIGENERE,
        METH_RC4,
        METH_NONE
    } method_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KSA_A,
        ST_KSA_B,
        ST_KSA_C,
        ST_KSA_D,
        ST_RC_I,
        ST_RC_J,
        ST_RC_SWAP,
        ST_RC_OUT,
        ST_DONE
    } st_t;

endpackage

// ===== hdl/byte_stream_cipher.sv =====
// Byte stream cipher top level: Caesar, Vigenere and RC4 over one byte stream.
// Depends on bsc_pkg and byte_stream_cipher_macros.svh.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: data_byte; tuser: mode; tlast: last_in
// m_*       out        m_tvalid/m_tready  tdata: result_byte; tlast: last_out
// cfg_*     in         cfg_we only        cfg_index, cfg_data
//
// Caesar, Vigenere and pass-through items go from accept through the result register and
// the DONE state into the output register. A ready-table RC4 item runs RC_J, RC_SWAP,
// RC_OUT, then DONE; the single-port-pair permutation memory sets this sequence
// (read S[i], read S[j] and write S[i], write S[j] with S[t] read back).
// The first RC4 item after reset or a write to a defined register first builds the table:
// a fill pass over all 256 entries, then KSA_A to KSA_D for each of 256 schedule steps,
// then RC_I to step i. DONE waits while the output register holds an untaken result.
// Reset clears control state only; the table needs no clearing pass.
// The input side takes an item whenever the sequencer is idle, even while a result waits.
`include "byte_stream_cipher_macros.svh"

module byte_stream_cipher #(
    parameter int KEY_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] mode
    input  logic                          s_tlast,
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsc_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] result_byte
    output logic                          m_tlast,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0]     cfg_data
);
    import bsc_pkg::*;

    localparam int KP_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int TA_W = $clog2(TABLE_D);

    // Configuration registers
    method_t                  method_reg;
    logic [BYTE_W-1:0]        shift_reg;
    logic [KLEN_W-1:0]        key_len_reg;
    logic [BYTE_W-1:0]        key_reg [KEY_BYTES];

    // Sequencer and RC4 state
    st_t                      state_reg, state_next;
    logic                     table_ready_reg, table_ready_next;
    logic [BYTE_W-1:0]        i_reg, i_next;
    logic [BYTE_W-1:0]        j_reg, j_next;
    logic [KP_W-1:0]          kpos_reg, kpos_next;
    logic [TA_W-1:0]          cnt_reg, cnt_next;
    logic [BYTE_W-1:0]        b_reg, b_next;
    logic [KP_W-1:0]          kidx_reg, kidx_next;

    // Payload registers
    logic [BYTE_W-1:0]        data_reg, data_next;
    logic                     last_reg, last_next;
    logic [BYTE_W-1:0]        res_reg, res_next;
    logic [BYTE_W-1:0]        sa_reg, sa_next;
    logic [BYTE_W-1:0]        sj_reg, sj_next;
    logic [BYTE_W-1:0]        t_reg, t_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]        out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    // Permutation table
    logic [BYTE_W-1:0]        table_mem [TABLE_D];
    logic [BYTE_W-1:0]        mem_rd_reg;
    logic [TA_W-1:0]          mem_raddr;
    logic                     mem_we;
    logic [TA_W-1:0]          mem_waddr;
    logic [BYTE_W-1:0]        mem_wdata;

    // Shared helpers
    logic                     accept;
    logic                     cfg_hit;
    logic                     out_free;
    logic [KLEN_W-1:0]        eff_len;
    logic [KP_W-1:0]          key_sel;
    logic [BYTE_W-1:0]        key_byte;
    logic [BYTE_W-1:0]        b_sum;
    logic [BYTE_W-1:0]        j_sum;
    logic [BYTE_W-1:0]        keystream;

    assign accept   = s_tvalid && s_tready;
    assign cfg_hit  = cfg_we && (cfg_index <= CFG_KEY_HIGH);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Clamp the key length to 1..KEY_BYTES
    always_comb
    begin
        if (key_len_reg == '0)
            eff_len = KLEN_W'(1);
        else if (key_len_reg > KLEN_W'(KEY_BYTES))
            eff_len = KLEN_W'(KEY_BYTES);
        else
            eff_len = key_len_reg;
    end

    // One key read port, shared by the key schedule and Vigenere
    assign key_sel  = (state_reg == ST_KSA_B) ? kidx_reg : kpos_reg;
    assign key_byte = key_reg[key_sel];

    assign b_sum = b_reg + mem_rd_reg + key_byte;
    assign j_sum = j_reg + mem_rd_reg;

    // Forward the swapped values when the output index hits i or j
    always_comb
    begin
        if (t_reg == i_reg)
            keystream = sj_reg;
        else if (t_reg == j_reg)
            keystream = sa_reg;
        else
            keystream = mem_rd_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (method_reg == METH_RC4)
                        state_next = table_ready_reg ? ST_RC_J : ST_FILL;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_FILL:    state_next = (cnt_reg == '1) ? ST_KSA_A : ST_FILL;
            ST_KSA_A:   state_next = ST_KSA_B;
            ST_KSA_B:   state_next = ST_KSA_C;
            ST_KSA_C:   state_next = ST_KSA_D;
            ST_KSA_D:   state_next = (cnt_reg == '1) ? ST_RC_I : ST_KSA_A;
            ST_RC_I:    state_next = ST_RC_J;
            ST_RC_J:    state_next = ST_RC_SWAP;
            ST_RC_SWAP: state_next = ST_RC_OUT;
            ST_RC_OUT:  state_next = ST_DONE;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls per state
    always_comb
    begin
        table_ready_next = table_ready_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        kpos_next        = kpos_reg;
        cnt_next         = cnt_reg;
        b_next           = b_reg;
        kidx_next        = kidx_reg;
        data_next        = data_reg;
        last_next        = last_reg;
        res_next         = res_reg;
        sa_next          = sa_reg;
        sj_next          = sj_reg;
        t_next           = t_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        mem_raddr        = i_reg + 8'd1;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // S[i+1] is read here so a ready table can skip the RC_I state
                if (accept)
                begin
                    data_next = s_tdata;
                    last_next = s_tlast;
                    cnt_next  = '0;
                    case (method_reg)
                        METH_CAESAR:
                            res_next = s_tuser ? (s_tdata - shift_reg) : (s_tdata + shift_reg);
                        METH_VIGENERE:
                        begin
                            res_next = s_tuser ? (s_tdata - key_byte) : (s_tdata + key_byte);
                            if ((KLEN_W'(kpos_reg) + KLEN_W'(1)) >= eff_len)
                                kpos_next = '0;
                            else
                                kpos_next = kpos_reg + KP_W'(1);
                        end
                        METH_RC4:
                        begin
                            if (table_ready_reg)
                                i_next = i_reg + 8'd1;
                        end
                        METH_NONE:
                            res_next = s_tdata;
                        default:
                            res_next = s_tdata;
                    endcase
                end
            end
            ST_FILL:
            begin
                // Load the identity permutation
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = cnt_reg;
                cnt_next  = cnt_reg + TA_W'(1);
                b_next    = '0;
                kidx_next = '0;
            end
            ST_KSA_A:
            begin
                mem_raddr = cnt_reg;
            end
            ST_KSA_B:
            begin
                sa_next   = mem_rd_reg;
                b_next    = b_sum;
                mem_raddr = b_sum;
            end
            ST_KSA_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = mem_rd_reg;
            end
            ST_KSA_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg;
                mem_wdata = sa_reg;
                cnt_next  = cnt_reg + TA_W'(1);
                if ((KLEN_W'(kidx_reg) + KLEN_W'(1)) >= eff_len)
                    kidx_next = '0;
                else
                    kidx_next = kidx_reg + KP_W'(1);
                if (cnt_reg == '1)
                begin
                    table_ready_next = 1'b1;
                    i_next           = '0;
                    j_next           = '0;
                end
            end
            ST_RC_I:
            begin
                i_next = i_reg + 8'd1;
            end
            ST_RC_J:
            begin
                sa_next   = mem_rd_reg;
                j_next    = j_sum;
                mem_raddr = j_sum;
            end
            ST_RC_SWAP:
            begin
                // S[i] takes S[j]; read S[S[i]+S[j]] before the second write lands
                sj_next   = mem_rd_reg;
                t_next    = sa_reg + mem_rd_reg;
                mem_raddr = sa_reg + mem_rd_reg;
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = mem_rd_reg;
            end
            ST_RC_OUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
                res_next  = data_reg ^ keystream;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_last_next  = last_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        // A write to a defined register restarts the key position and the keystream
        if (cfg_hit)
        begin
            kpos_next        = '0;
            i_next           = '0;
            j_next           = '0;
            table_ready_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_ready_reg <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            kpos_reg        <= '0;
            cnt_reg         <= '0;
            b_reg           <= '0;
            kidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            table_ready_reg <= table_ready_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            kpos_reg        <= kpos_next;
            cnt_reg         <= cnt_next;
            b_reg           <= b_next;
            kidx_reg        <= kidx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        last_reg     <= last_next;
        res_reg      <= res_next;
        sa_reg       <= sa_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Scalar configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg  <= METH_CAESAR;
            shift_reg   <= '0;
            key_len_reg <= KLEN_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_METHOD)
                method_reg <= method_t'(cfg_data[1:0]);
            if (cfg_index == CFG_SHIFT)
                shift_reg <= cfg_data[BYTE_W-1:0];
            if (cfg_index == CFG_KEY_LEN)
                key_len_reg <= cfg_data[KLEN_W-1:0];
        end
    end

    // Key bytes: low word holds bytes 0..7, high word bytes 8 and up
    for (genvar k = 0; k < KEY_BYTES; k++)
    begin : g_key
        if (k < 8)
        begin : g_low
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    key_reg[k] <= '0;
                else if (cfg_we && (cfg_index == CFG_KEY_LOW))
                    key_reg[k] <= cfg_data[BYTE_W*k +: BYTE_W];
            end
        end
        else
        begin : g_high
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    key_reg[k] <= '0;
                else if (cfg_we && (cfg_index == CFG_KEY_HIGH))
                    key_reg[k] <= cfg_data[BYTE_W*(k-8) +: BYTE_W];
            end
        end
    end

    // Permutation table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= table_mem[mem_raddr];
    end

    // Checks
    `BSC_CHECK(a_kpos_range, 1'b1, (KLEN_W'(kpos_reg) < eff_len),
               "key position beyond key length")
    `BSC_CHECK_NEXT(a_cfg_clear, cfg_hit,
                    (!table_ready_reg && i_reg == '0 && j_reg == '0),
                    "register write did not restart keystream")
    `BSC_CHECK_NEXT(a_done_load, (state_reg == ST_DONE && out_free), out_valid_reg,
                    "result not loaded into output register")
    `BSC_CHECK_NEXT(a_rc4_fast, (accept && method_reg == METH_RC4 && table_ready_reg),
                    (state_reg == ST_RC_J), "ready table did not skip the schedule")
    `BSC_CHECK(a_ready_sched, $rose(table_ready_reg), (state_reg == ST_RC_I),
               "table marked ready outside schedule end")

endmodule

// ===== tb/sv/byte_stream_cipher_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for byte_stream_cipher: Caesar, Vigenere, RC4 and pass-through.
// Depends on bsc_pkg and the byte_stream_cipher RTL; holds its own cipher predictor.
module byte_stream_cipher_tb;
    import bsc_pkg::*;

    localparam int KEY_BYTES      = 16;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD      = 120;
    localparam int RANDOM_BYTES   = 1100;
    localparam int REPORT_MAX     = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_IDX_W'(CFG_KEY_HIGH + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = '1;

    typedef struct packed {
        logic             decrypt;
        logic [BYTE_W-1:0] text;
        logic             last;
    } plain_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic             last;
    } cipher_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;    // [7:0] data_byte
    logic                 s_tuser = 1'b0;  // [0] mode
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;         // [7:0] result_byte
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor state
    method_t              cur_method;
    logic [BYTE_W-1:0]    cur_shift;
    logic [KLEN_W-1:0]    cur_klen;
    logic [CFG_W-1:0]     cur_key_lo;
    logic [CFG_W-1:0]     cur_key_hi;
    logic [BYTE_W-1:0]    sbox [TABLE_D];
    logic                 sbox_built;
    logic [BYTE_W-1:0]    ptr_i;
    logic [BYTE_W-1:0]    ptr_j;
    logic [3:0]           vig_pos;

    plain_item_t  bytes_to_send [$];
    cipher_item_t cipher_expected [$];
    int           mismatches = 0;
    int           src_gap_max = 0;
    int           snk_gap_max = 0;
    int           src_wait = 0;
    int           snk_wait = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    byte_stream_cipher #(.KEY_BYTES(KEY_BYTES)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Number of key bytes in use, with out-of-range lengths clamped
    function automatic int key_span();
        int n;
        n = int'(cur_klen);
        if (n == 0) n = 1;
        if (n > KEY_BYTES) n = KEY_BYTES;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] key_at(int k);
        k = k & 15;
        if (k < 8) return cur_key_lo[8*k +: 8];
        return cur_key_hi[8*(k-8) +: 8];
    endfunction

    // RC4 key schedule over the current key
    function automatic void build_sbox();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] t;
        int                n;
        n = key_span();
        b = '0;
        for (int a = 0; a < TABLE_D; a++) sbox[a] = BYTE_W'(a);
        for (int a = 0; a < TABLE_D; a++)
        begin
            b = b + sbox[a] + key_at(a % n);
            t = sbox[a];
            sbox[a] = sbox[b];
            sbox[b] = t;
        end
        sbox_built = 1'b1;
        ptr_i = '0;
        ptr_j = '0;
    endfunction

    function automatic logic [BYTE_W-1:0] keystream_byte();
        logic [BYTE_W-1:0] t;
        ptr_i = ptr_i + 1'b1;
        ptr_j = ptr_j + sbox[ptr_i];
        t = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = t;
        t = sbox[ptr_i] + sbox[ptr_j];
        return sbox[t];
    endfunction

    // Expected output for one accepted byte; advances the cipher state
    function automatic cipher_item_t cipher_byte(logic decrypt, logic [BYTE_W-1:0] d,
                                                 logic last);
        cipher_item_t      r;
        logic [BYTE_W-1:0] k;
        r.text = d;
        r.last = last;
        case (cur_method)
            METH_CAESAR:
                r.text = decrypt ? d - cur_shift : d + cur_shift;
            METH_VIGENERE:
            begin
                k = key_at(int'(vig_pos));
                r.text = decrypt ? d - k : d + k;
                if (int'(vig_pos) + 1 >= key_span()) vig_pos = '0;
                else vig_pos = vig_pos + 1'b1;
            end
            METH_RC4:
            begin
                if (!sbox_built) build_sbox();
                r.text = d ^ keystream_byte();
            end
            default: ;
        endcase
        return r;
    endfunction

    // Register write as the block sees it; spare indexes leave everything alone
    function automatic void track_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        case (idx)
            CFG_METHOD:   cur_method = method_t'(v[1:0]);
            CFG_SHIFT:    cur_shift  = v[BYTE_W-1:0];
            CFG_KEY_LEN:  cur_klen   = v[KLEN_W-1:0];
            CFG_KEY_LOW:  cur_key_lo = v;
            CFG_KEY_HIGH: cur_key_hi = v;
            default:      return;
        endcase
        vig_pos    = '0;
        ptr_i      = '0;
        ptr_j      = '0;
        sbox_built = 1'b0;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        track_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void queue_byte(logic decrypt, logic [BYTE_W-1:0] d, logic last);
        plain_item_t it;
        it.decrypt = decrypt;
        it.text    = d;
        it.last    = last;
        bytes_to_send.push_back(it);
    endfunction

    // Hold until every queued item is in and every result has come back
    task automatic drain();
        while (bytes_to_send.size() > 0 || s_tvalid || cipher_expected.size() > 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Source: offer queued items, with a random gap after each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        plain_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_wait  = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                cipher_expected.push_back(cipher_byte(s_tuser, s_tdata, s_tlast));
                src_wait = $urandom_range(0, src_gap_max);
            end
            if (src_wait > 0)
            begin
                src_wait--;
                s_tvalid <= 1'b0;
            end
            else if (bytes_to_send.size() > 0)
            begin
                it = bytes_to_send.pop_front();
                s_tdata  <= it.text;
                s_tuser  <= it.decrypt;
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink: check each result against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        cipher_item_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result byte %02h last %b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (m_tdata !== want.text || m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: byte expected %02h last %b, got %02h last %b",
                                     $time, want.text, want.last, m_tdata, m_tlast);
                    end
                end
                snk_wait = $urandom_range(0, snk_gap_max);
            end
            if (hold_served < hold_requests)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int      sent;
        int      n;
        int      phase;
        int      pick;
        method_t m;

        cur_method = METH_CAESAR;
        cur_shift  = '0;
        cur_klen   = KLEN_W'(1);
        cur_key_lo = '0;
        cur_key_hi = '0;
        sbox_built = 1'b0;
        ptr_i      = '0;
        ptr_j      = '0;
        vig_pos    = '0;
        for (int a = 0; a < TABLE_D; a++) sbox[a] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: Caesar with no shift
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b1, 8'hFF, 1'b1);
        drain();

        // Largest shift, wrapping both ways
        write_reg(CFG_SHIFT, 64'd255);
        queue_byte(1'b0, 8'h01, 1'b0);
        queue_byte(1'b1, 8'h00, 1'b1);
        drain();

        // Vigenere with zero key length, used as one
        write_reg(CFG_METHOD, CFG_W'(METH_VIGENERE));
        write_reg(CFG_KEY_LEN, 64'd0);
        write_reg(CFG_KEY_LOW, '1);
        queue_byte(1'b0, 8'h80, 1'b0);
        queue_byte(1'b1, 8'h7F, 1'b1);
        drain();

        // Three-byte key; a spare register write must not reset the key position
        write_reg(CFG_KEY_LEN, 64'd3);
        write_reg(CFG_KEY_LOW, 64'h0000_0000_00C3_8201);
        queue_byte(1'b0, 8'h10, 1'b0);
        queue_byte(1'b1, 8'h20, 1'b0);
        drain();
        write_reg(CFG_FIRST_SPARE, '1);
        queue_byte(1'b0, 8'h30, 1'b0);
        queue_byte(1'b0, 8'hFE, 1'b1);
        drain();

        // RC4 with an oversized key length, used as the full key
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LEN, 64'd31);
        write_reg(CFG_METHOD, CFG_W'(METH_RC4));
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b1, 8'hFF, 1'b0);
        queue_byte(1'b0, 8'h55, 1'b0);
        queue_byte(1'b1, 8'hAA, 1'b1);
        drain();

        // Unused method passes bytes through
        write_reg(CFG_METHOD, CFG_W'(METH_NONE));
        queue_byte(1'b0, 8'hA5, 1'b0);
        queue_byte(1'b1, 8'h5A, 1'b1);
        drain();

        // Random phases, each with its own settings and idling profile
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      m = METH_CAESAR;
            else if (pick < 6) m = METH_VIGENERE;
            else if (pick < 9) m = METH_RC4;
            else               m = METH_NONE;
            // Keep the hold-off phase short per item so the block fills within the hold
            if (phase == 1)
                m = METH_CAESAR;

            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_SHIFT, 64'd0);
                    1:       write_reg(CFG_SHIFT, 64'd255);
                    default: write_reg(CFG_SHIFT, CFG_W'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 7))
                    0:       write_reg(CFG_KEY_LEN, 64'd0);
                    1:       write_reg(CFG_KEY_LEN, 64'd1);
                    2:       write_reg(CFG_KEY_LEN, CFG_W'(KEY_BYTES));
                    3:       write_reg(CFG_KEY_LEN, CFG_W'($urandom_range(KEY_BYTES + 1, 31)));
                    default: write_reg(CFG_KEY_LEN, CFG_W'($urandom_range(1, KEY_BYTES)));
                endcase
            end
            if ($urandom_range(0, 1)) write_reg(CFG_KEY_LOW, pick_key());
            if ($urandom_range(0, 1)) write_reg(CFG_KEY_HIGH, pick_key());
            write_reg(CFG_METHOD, CFG_W'(m));
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)),
                          {$urandom, $urandom});

            // Second phase: back-to-back source against a long sink hold-off
            if (phase == 1)
            begin
                src_gap_max = 0;
                snk_gap_max = 6;
                hold_requests++;
            end
            else
            begin
                src_gap_max = $urandom_range(0, 2) == 0 ? 0 : 6;
                snk_gap_max = $urandom_range(0, 2) == 0 ? 0 : 6;
            end

            @(negedge clk);
            n = $urandom_range(40, 90);
            for (int b = 0; b < n; b++)
                queue_byte(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                           $urandom_range(0, 7) == 0 || b == n - 1);
            sent += n;
            phase++;
            drain();
        end

        // Let any stray result show up before judging
        repeat (20) @(posedge clk);
        if (mismatches == 0 && cipher_expected.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (cipher_expected.size() > 0)
                $display("%0d expected results never arrived", cipher_expected.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bsc_pkg.sv
hdl/byte_stream_cipher.sv
tb/sv/byte_stream_cipher_tb.sv
